// ===== rtl/slbt_pkg.sv =====
// ----------------------------------------------------------------------------
// slbt_pkg: shared types and constants
// Result layout, tick phase codes, animation modes, event codes and limits.
// ----------------------------------------------------------------------------
`default_nettype none

package slbt_pkg;

    localparam int CFG_DATA_W = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_PIN   = 1'd1;

    localparam logic [2:0] FUNC_TIMER = 3'd0;
    localparam logic [2:0] FUNC_BLINK = 3'd1;
    localparam logic [2:0] FUNC_PULSE = 3'd2;
    localparam logic [2:0] FUNC_VOL   = 3'd3;
    localparam logic [2:0] FUNC_MAIN  = 3'd4;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_BLINK = 2'd1;
    localparam logic [1:0] MODE_PULSE = 2'd2;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_HELD   = 3'd1;
    localparam logic [2:0] EV_RESET  = 3'd2;
    localparam logic [2:0] EV_LISTEN = 3'd3;
    localparam logic [2:0] EV_VOLUME = 3'd4;

    localparam logic [7:0] BLINK_PERIOD  = 8'd100;
    localparam logic [7:0] PULSE_PERIOD  = 8'd16;
    localparam logic [5:0] VOL_QUALIFY   = 6'd50;
    localparam logic [8:0] MAIN_QUALIFY  = 9'd50;
    localparam logic [8:0] MAIN_LONG     = 9'd500;

    typedef struct packed {
        logic       pin_write;
        logic [2:0] pin_index;
        logic       pin_level;
        logic [2:0] btn_event;
        logic       is_last;
    } result_t;

    typedef struct packed {
        logic    push_one;
        logic    push_two;
        result_t first;
        result_t second;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/slbt_ifs.sv =====
// ----------------------------------------------------------------------------
// slbt_ifs: channel interfaces
// Valid/ready channels for input ticks and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface slbt_tick_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic       main_btn;
    logic       vol_btn;

    modport source (output valid, output func, output main_btn, output vol_btn,
                    input ready);
    modport sink   (input valid, input func, input main_btn, input vol_btn,
                    output ready);
endinterface

interface slbt_result_if;
    logic       valid;
    logic       ready;
    logic       pin_write;
    logic [2:0] pin_index;
    logic       pin_level;
    logic [2:0] btn_event;
    logic       is_last;

    modport source (output valid, output pin_write, output pin_index,
                    output pin_level, output btn_event, output is_last,
                    input ready);
    modport sink   (input valid, input pin_write, input pin_index,
                    input pin_level, input btn_event, input is_last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/slbt_core.sv =====
// ----------------------------------------------------------------------------
// slbt_core: tick processing
// Holds configuration and animation/button state, updates it on each tick
// transfer and forms the one or two result items of that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module slbt_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [2:0]                        func,
    input  wire logic                              main_btn,
    input  wire logic                              vol_btn,
    input  wire logic                              cfg_wen,
    input  wire logic [slbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [slbt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output slbt_pkg::push_t                        push
);

    logic [1:0] anim_mode_reg;
    logic [2:0] led_pin_reg;
    logic [7:0] anim_timer_reg,  anim_timer_next;
    logic [5:0] duty_step_reg,   duty_step_next;
    logic       led_level_reg,   led_level_next;
    logic [8:0] main_count_reg,  main_count_next;
    logic [5:0] vol_count_reg,   vol_count_next;
    logic       prev_main_reg,   prev_main_next;
    logic       prev_vol_reg,    prev_vol_next;
    logic [2:0] event_code_reg,  event_code_next;

    logic       wr_a, lv_a, wr_b;
    logic [7:0] blink_t;
    logic [8:0] main_c;
    logic [5:0] vol_c;
    logic       main_held, vol_held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_mode_reg <= slbt_pkg::MODE_OFF;
            led_pin_reg   <= 3'd0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                slbt_pkg::CFG_ANIM_MODE: anim_mode_reg <= cfg_data[1:0];
                slbt_pkg::CFG_LED_PIN:   led_pin_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        anim_timer_next = anim_timer_reg;
        duty_step_next  = duty_step_reg;
        led_level_next  = led_level_reg;
        main_count_next = main_count_reg;
        vol_count_next  = vol_count_reg;
        prev_main_next  = prev_main_reg;
        prev_vol_next   = prev_vol_reg;
        event_code_next = event_code_reg;
        wr_a      = 1'b0;
        lv_a      = 1'b0;
        wr_b      = 1'b0;
        blink_t   = 8'd0;
        main_c    = 9'd0;
        vol_c     = 6'd0;
        main_held = main_btn & prev_main_reg;
        vol_held  = vol_btn & prev_vol_reg;

        unique case (func)
            slbt_pkg::FUNC_TIMER:
            begin
                if (anim_mode_reg == slbt_pkg::MODE_BLINK ||
                    anim_mode_reg == slbt_pkg::MODE_PULSE)
                    anim_timer_next = anim_timer_reg + 8'd1;
                else
                    anim_timer_next = 8'd0;
            end
            slbt_pkg::FUNC_BLINK:
            begin
                if (anim_mode_reg == slbt_pkg::MODE_BLINK)
                begin
                    blink_t = (anim_timer_reg == slbt_pkg::BLINK_PERIOD) ?
                              8'd0 : anim_timer_reg;
                    anim_timer_next = blink_t;
                    if (blink_t == 8'd0)
                    begin
                        led_level_next = ~led_level_reg;
                        wr_a = 1'b1;
                        lv_a = ~led_level_reg;
                    end
                end
            end
            slbt_pkg::FUNC_PULSE:
            begin
                if (anim_mode_reg == slbt_pkg::MODE_PULSE)
                begin
                    if (anim_timer_reg == slbt_pkg::PULSE_PERIOD)
                    begin
                        anim_timer_next = 8'd0;
                        duty_step_next  = duty_step_reg + 6'd1;
                        wr_a = 1'b1;
                        lv_a = 1'b1;
                    end
                    if (anim_timer_next == {4'd0, duty_step_next[5:2]})
                    begin
                        if (wr_a)
                            wr_b = 1'b1;
                        else
                        begin
                            wr_a = 1'b1;
                            lv_a = 1'b0;
                        end
                    end
                end
            end
            slbt_pkg::FUNC_VOL:
            begin
                vol_c = (vol_btn && !prev_vol_reg) ? 6'd1 : vol_count_reg;
                if (vol_c != 6'd0)
                begin
                    vol_c = vol_c + 6'd1;
                    if (vol_c == slbt_pkg::VOL_QUALIFY)
                    begin
                        if (vol_held)
                            event_code_next = slbt_pkg::EV_VOLUME;
                        vol_c = 6'd0;
                    end
                end
                vol_count_next = vol_c;
                prev_vol_next  = vol_btn;
            end
            slbt_pkg::FUNC_MAIN:
            begin
                main_c = (main_btn && !prev_main_reg) ? 9'd1 : main_count_reg;
                if (main_c != 9'd0)
                begin
                    main_c = main_c + 9'd1;
                    if (main_c == slbt_pkg::MAIN_QUALIFY)
                    begin
                        if (main_held)
                            event_code_next = slbt_pkg::EV_HELD;
                        else
                            main_c = 9'd0;
                    end
                    if (event_code_next == slbt_pkg::EV_HELD &&
                        main_c == slbt_pkg::MAIN_LONG)
                    begin
                        event_code_next = main_held ? slbt_pkg::EV_RESET :
                                                      slbt_pkg::EV_LISTEN;
                        main_c = 9'd0;
                    end
                end
                main_count_next = main_c;
                prev_main_next  = main_btn;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_timer_reg <= 8'd0;
            duty_step_reg  <= 6'd0;
            led_level_reg  <= 1'b0;
            main_count_reg <= 9'd0;
            vol_count_reg  <= 6'd0;
            prev_main_reg  <= 1'b0;
            prev_vol_reg   <= 1'b0;
            event_code_reg <= slbt_pkg::EV_NONE;
        end
        else if (accept)
        begin
            anim_timer_reg <= anim_timer_next;
            duty_step_reg  <= duty_step_next;
            led_level_reg  <= led_level_next;
            main_count_reg <= main_count_next;
            vol_count_reg  <= vol_count_next;
            prev_main_reg  <= prev_main_next;
            prev_vol_reg   <= prev_vol_next;
            event_code_reg <= event_code_next;
        end
    end

    always_comb
    begin
        push.push_one = accept & ~wr_b;
        push.push_two = accept & wr_b;

        push.first.pin_write = wr_a;
        push.first.pin_index = wr_a ? led_pin_reg : 3'd0;
        push.first.pin_level = wr_a & lv_a;
        push.first.btn_event = event_code_next;
        push.first.is_last   = ~wr_b;

        push.second.pin_write = 1'b1;
        push.second.pin_index = led_pin_reg;
        push.second.pin_level = 1'b0;
        push.second.btn_event = event_code_next;
        push.second.is_last   = 1'b1;
    end

endmodule

`default_nettype wire

// ===== rtl/slbt_outq.sv =====
// ----------------------------------------------------------------------------
// slbt_outq: result queue
// Small register queue that takes one or two results per tick and hands
// them to the result channel one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module slbt_outq #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire slbt_pkg::push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output slbt_pkg::result_t      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slbt_pkg::result_t mem_reg [DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] tail_p1, tail_p2;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign tail_p1   = wrap_inc(tail_reg);
    assign tail_p2   = wrap_inc(tail_p1);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[head_reg];
    assign pop       = out_valid & out_ready;
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        head_next  = pop ? wrap_inc(head_reg) : head_reg;
        tail_next  = tail_reg;
        count_next = count_reg - CNT_W'(pop);
        priority if (push.push_two)
        begin
            tail_next  = tail_p2;
            count_next = count_reg + CNT_W'(2) - CNT_W'(pop);
        end
        else if (push.push_one)
        begin
            tail_next  = tail_p1;
            count_next = count_reg + CNT_W'(1) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_one || push.push_two)
            mem_reg[tail_reg] <= push.first;
        if (push.push_two)
            mem_reg[tail_p1] <= push.second;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count exceeds depth");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.push_one || push.push_two) |-> room)
        else $error("push into result queue without room");

    a_single_push: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.push_one && push.push_two))
        else $error("push of one and two results at once");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.push_two |-> (!push.first.is_last && push.second.is_last))
        else $error("result pair does not end on its second item");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push.push_one && !push.push_two) |=>
        count_reg == $past(count_reg) - CNT_W'(1))
        else $error("result queue count wrong after transfer");

endmodule

`default_nettype wire

// ===== rtl/status_led_and_button_tick.sv =====
// ----------------------------------------------------------------------------
// status_led_and_button_tick: status LED animation and button qualifier
// Top level: tick channel in, result channel out, plain configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one timer tick per transfer (phase code and raw button levels).
//   result : one result per tick, two for a pulse tick that raises and then
//            lowers the pin; is_last marks the final result of a tick.
//   cfg    : write anim_mode (index 0) or led_pin (index 1) while idle.
// Order: the first result of a tick is written into the result queue on its
//   transfer; the second one follows on the next result transfer.
// Throughput: one tick per cycle while the receiver keeps up; a two-result
//   tick costs two result transfers. The FIFO_DEPTH-entry result queue sets
//   the figure: a tick is taken only while two entries are free.
// Reset: all animation and button state clears, the LED level is down, no
//   event is pending and the result queue is empty.
// Stall: a stalled receiver holds the head result; ticks keep being taken
//   until fewer than two queue entries are free, then tick ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_and_button_tick #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    slbt_tick_if.sink                            tick,
    slbt_result_if.source                        result,
    input  wire logic                            cfg_wen,
    input  wire logic [slbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slbt_pkg::CFG_DATA_W-1:0] cfg_data
);

    slbt_pkg::push_t   push;
    slbt_pkg::result_t head;
    logic              room;
    logic              accept;

    assign tick.ready = room;
    assign accept     = tick.valid & room;

    slbt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (tick.func),
        .main_btn  (tick.main_btn),
        .vol_btn   (tick.vol_btn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    slbt_outq #(
        .DEPTH (FIFO_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (head)
    );

    assign result.pin_write = head.pin_write;
    assign result.pin_index = head.pin_index;
    assign result.pin_level = head.pin_level;
    assign result.btn_event = head.btn_event;
    assign result.is_last   = head.is_last;

endmodule

`default_nettype wire

// ===== test/status_led_and_button_tick_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_and_button_tick_tb: tick-level check of LED animation and buttons
// Walks a short table of ticks and register writes, then runs phases of
// random animation bursts and button presses under several handshake
// patterns. A tick-by-tick model of the timer, blink, pulse ramp and both
// button qualifiers predicts every result transfer, and each one is compared
// field by field in order.
// ----------------------------------------------------------------------------

module status_led_and_button_tick_tb;

    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam logic [2:0] FUNC_SPARE_A = 3'd5;
    localparam logic [2:0] FUNC_SPARE_B = 3'd6;
    localparam logic [2:0] FUNC_SPARE_C = 3'd7;

    localparam slbt_pkg::result_t QUIET      =
        '{1'b0, 3'd0, 1'b0, slbt_pkg::EV_NONE, 1'b1};
    localparam slbt_pkg::result_t BLINK_UP_7 =
        '{1'b1, 3'd7, 1'b1, slbt_pkg::EV_NONE, 1'b1};
    localparam slbt_pkg::result_t PULSE_DN_0 =
        '{1'b1, 3'd0, 1'b0, slbt_pkg::EV_NONE, 1'b1};

    typedef struct {
        bit                              is_cfg;
        logic [slbt_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [slbt_pkg::CFG_DATA_W-1:0] reg_val;
        logic [2:0]                      func;
        logic                            main_lvl;
        logic                            vol_lvl;
        bit                              typed;
        slbt_pkg::result_t               want;
    } dir_row_t;

    localparam int DIR_ROWS = 23;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          FUNC_SPARE_A, 1'b1, 1'b1, 1'b1, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          FUNC_SPARE_C, 1'b0, 1'b1, 1'b1, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          FUNC_SPARE_B, 1'b1, 1'b0, 1'b1, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_BLINK, 1'b0, 1'b0, 1'b1, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_PULSE, 1'b1, 1'b1, 1'b1, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_TIMER, 1'b1, 1'b1, 1'b1, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_VOL, 1'b0, 1'b1, 1'b1, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_MAIN, 1'b1, 1'b0, 1'b1, QUIET},
        '{1'b1, slbt_pkg::CFG_LED_PIN, 3'd7,
          slbt_pkg::FUNC_TIMER, 1'b0, 1'b0, 1'b0, QUIET},
        '{1'b1, slbt_pkg::CFG_ANIM_MODE, {1'b0, slbt_pkg::MODE_BLINK},
          slbt_pkg::FUNC_TIMER, 1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_BLINK, 1'b0, 1'b1, 1'b1, BLINK_UP_7},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_TIMER, 1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_BLINK, 1'b0, 1'b0, 1'b0, QUIET},
        '{1'b1, slbt_pkg::CFG_ANIM_MODE, {1'b0, slbt_pkg::MODE_PULSE},
          slbt_pkg::FUNC_TIMER, 1'b0, 1'b0, 1'b0, QUIET},
        '{1'b1, slbt_pkg::CFG_LED_PIN, 3'd0,
          slbt_pkg::FUNC_TIMER, 1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_PULSE, 1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_TIMER, 1'b0, 1'b1, 1'b0, QUIET},
        '{1'b1, slbt_pkg::CFG_ANIM_MODE, {1'b0, MODE_SPARE},
          slbt_pkg::FUNC_TIMER, 1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_TIMER, 1'b0, 1'b0, 1'b1, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_PULSE, 1'b1, 1'b1, 1'b1, QUIET},
        '{1'b1, slbt_pkg::CFG_ANIM_MODE, {1'b0, slbt_pkg::MODE_PULSE},
          slbt_pkg::FUNC_TIMER, 1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          slbt_pkg::FUNC_PULSE, 1'b0, 1'b0, 1'b1, PULSE_DN_0},
        '{1'b0, slbt_pkg::CFG_ANIM_MODE, 3'd0,
          FUNC_SPARE_C, 1'b0, 1'b0, 1'b0, QUIET}
    };

    localparam logic [1:0] PHASE_MODE [8] = '{
        slbt_pkg::MODE_BLINK, slbt_pkg::MODE_PULSE, slbt_pkg::MODE_OFF,
        slbt_pkg::MODE_PULSE, slbt_pkg::MODE_BLINK, MODE_SPARE,
        slbt_pkg::MODE_PULSE, slbt_pkg::MODE_BLINK
    };

    logic clk;
    logic rst_n;
    logic                            cfg_wen;
    logic [slbt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [slbt_pkg::CFG_DATA_W-1:0] cfg_data;

    slbt_tick_if   tick_ch ();
    slbt_result_if res_ch ();

    status_led_and_button_tick dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (res_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted block state
    logic [1:0] mode_cfg;
    logic [2:0] pin_cfg;
    logic [7:0] tmr;
    logic [5:0] ramp;
    logic       led_on;
    logic [8:0] main_cnt;
    logic [5:0] vol_cnt;
    logic       main_was;
    logic       vol_was;
    logic [2:0] last_event;

    slbt_pkg::result_t results_due [$];

    int tx_idle_pct;
    int stall_pct;
    int hold_cycles;
    int ticks_sent;
    int mismatches;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status_led_and_button_tick verification failed");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic step_led_and_buttons(input logic [2:0] f, input logic m, input logic v);
        logic lv [2];
        int   n;
        int   k;
        n = 0;
        case (f)
            slbt_pkg::FUNC_TIMER:
                tmr = (mode_cfg == slbt_pkg::MODE_BLINK ||
                       mode_cfg == slbt_pkg::MODE_PULSE) ? tmr + 8'd1 : 8'd0;
            slbt_pkg::FUNC_BLINK:
                if (mode_cfg == slbt_pkg::MODE_BLINK)
                begin
                    if (tmr == slbt_pkg::BLINK_PERIOD)
                        tmr = 8'd0;
                    if (tmr == 8'd0)
                    begin
                        led_on = ~led_on;
                        lv[n] = led_on;
                        n++;
                    end
                end
            slbt_pkg::FUNC_PULSE:
                if (mode_cfg == slbt_pkg::MODE_PULSE)
                begin
                    if (tmr == slbt_pkg::PULSE_PERIOD)
                    begin
                        tmr = 8'd0;
                        ramp = ramp + 6'd1;
                        lv[n] = 1'b1;
                        n++;
                    end
                    if (tmr == {4'd0, ramp[5:2]})
                    begin
                        lv[n] = 1'b0;
                        n++;
                    end
                end
            slbt_pkg::FUNC_VOL:
            begin
                if (v && !vol_was)
                    vol_cnt = 6'd1;
                if (vol_cnt != 6'd0)
                begin
                    vol_cnt = vol_cnt + 6'd1;
                    if (vol_cnt == slbt_pkg::VOL_QUALIFY)
                    begin
                        if (v && vol_was)
                            last_event = slbt_pkg::EV_VOLUME;
                        vol_cnt = 6'd0;
                    end
                end
                vol_was = v;
            end
            slbt_pkg::FUNC_MAIN:
            begin
                if (m && !main_was)
                    main_cnt = 9'd1;
                if (main_cnt != 9'd0)
                begin
                    main_cnt = main_cnt + 9'd1;
                    if (main_cnt == slbt_pkg::MAIN_QUALIFY)
                    begin
                        if (m && main_was)
                            last_event = slbt_pkg::EV_HELD;
                        else
                            main_cnt = 9'd0;
                    end
                    if (last_event == slbt_pkg::EV_HELD && main_cnt == slbt_pkg::MAIN_LONG)
                    begin
                        last_event = (m && main_was) ? slbt_pkg::EV_RESET :
                                                       slbt_pkg::EV_LISTEN;
                        main_cnt = 9'd0;
                    end
                end
                main_was = m;
            end
            default:
                ;
        endcase
        if (n == 0)
            results_due.push_back('{1'b0, 3'd0, 1'b0, last_event, 1'b1});
        for (k = 0; k < n; k++)
            results_due.push_back('{1'b1, pin_cfg, lv[k], last_event, k == n - 1});
    endtask

    task automatic offer_tick(input logic [2:0] f, input logic m, input logic v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            tick_ch.valid = 1'b0;
            @(negedge clk);
        end
        tick_ch.valid    = 1'b1;
        tick_ch.func     = f;
        tick_ch.main_btn = m;
        tick_ch.vol_btn  = v;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        step_led_and_buttons(f, m, v);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [slbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slbt_pkg::CFG_DATA_W-1:0] val);
        tick_ch.valid = 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wen = 1'b0;
        if (idx == slbt_pkg::CFG_ANIM_MODE)
            mode_cfg = val[1:0];
        else
            pin_cfg = val;
    endtask

    task automatic press_button(input logic [2:0] f, input int hold, input int tail,
                                input bit bouncy);
        int   k;
        logic lvl;
        for (k = -1; k < hold + tail; k++)
        begin
            lvl = (k >= 0) && (k < hold) && !(bouncy && $urandom_range(9) == 0);
            if ($urandom_range(7) == 0)
                offer_tick(3'($urandom_range(2)), 1'($urandom_range(1)), 1'($urandom_range(1)));
            if (f == slbt_pkg::FUNC_MAIN)
                offer_tick(f, lvl, 1'($urandom_range(1)));
            else
                offer_tick(f, 1'($urandom_range(1)), lvl);
        end
    endtask

    task automatic random_items(input int budget);
        int         stop_at;
        int         len;
        int         k;
        int         pick;
        logic [2:0] f;
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at)
        begin
            case ($urandom_range(7))
                0, 1, 2:
                begin
                    len = $urandom_range(20, 120);
                    for (k = 0; k < len && ticks_sent < stop_at; k++)
                    begin
                        pick = $urandom_range(7);
                        if (pick < 4)
                            f = slbt_pkg::FUNC_TIMER;
                        else if (pick < 7)
                            f = $urandom_range(1) ? slbt_pkg::FUNC_BLINK :
                                                    slbt_pkg::FUNC_PULSE;
                        else
                            f = 3'($urandom_range(7));
                        offer_tick(f, 1'($urandom_range(1)), 1'($urandom_range(1)));
                    end
                end
                3:
                    press_button(slbt_pkg::FUNC_VOL, $urandom_range(40, 60),
                                 $urandom_range(1, 8), $urandom_range(3) == 0);
                4:
                    press_button(slbt_pkg::FUNC_VOL, $urandom_range(2, 30),
                                 $urandom_range(20, 50), 1'b0);
                5:
                    press_button(slbt_pkg::FUNC_MAIN, $urandom_range(45, 70),
                                 $urandom_range(1, 10), $urandom_range(3) == 0);
                6:
                    press_button(slbt_pkg::FUNC_MAIN, $urandom_range(2, 40),
                                 $urandom_range(10, 60), 1'b0);
                default:
                begin
                    len = $urandom_range(10, 30);
                    for (k = 0; k < len && ticks_sent < stop_at; k++)
                        offer_tick(3'($urandom_range(7)), 1'($urandom_range(1)),
                                   1'($urandom_range(1)));
                end
            endcase
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
        begin
            res_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        slbt_pkg::result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                report("result with nothing due", res_ch.btn_event, -1);
            end
            else
            begin
                want = results_due.pop_front();
                if (res_ch.pin_write !== want.pin_write)
                    report("pin_write", res_ch.pin_write, want.pin_write);
                if (res_ch.pin_index !== want.pin_index)
                    report("pin_index", res_ch.pin_index, want.pin_index);
                if (res_ch.pin_level !== want.pin_level)
                    report("pin_level", res_ch.pin_level, want.pin_level);
                if (res_ch.btn_event !== want.btn_event)
                    report("btn_event", res_ch.btn_event, want.btn_event);
                if (res_ch.is_last !== want.is_last)
                    report("is_last", res_ch.is_last, want.is_last);
            end
        end
    end

    initial
    begin
        int p;
        int i;
        rst_n            = 1'b0;
        cfg_wen          = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        tick_ch.valid    = 1'b0;
        tick_ch.func     = slbt_pkg::FUNC_TIMER;
        tick_ch.main_btn = 1'b0;
        tick_ch.vol_btn  = 1'b0;
        res_ch.ready     = 1'b0;
        tx_idle_pct      = 0;
        stall_pct        = 0;
        hold_cycles      = 0;
        ticks_sent       = 0;
        mismatches       = 0;
        mode_cfg         = slbt_pkg::MODE_OFF;
        pin_cfg          = 3'd0;
        tmr              = 8'd0;
        ramp             = 6'd0;
        led_on           = 1'b0;
        main_cnt         = 9'd0;
        vol_cnt          = 6'd0;
        main_was         = 1'b0;
        vol_was          = 1'b0;
        last_event       = slbt_pkg::EV_NONE;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].is_cfg)
            begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
            begin
                offer_tick(dir_rows[i].func, dir_rows[i].main_lvl, dir_rows[i].vol_lvl);
                if (dir_rows[i].typed)
                    results_due[results_due.size() - 1] = dir_rows[i].want;
            end
        end

        for (p = 0; p < 8; p++)
        begin
            tx_idle_pct = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 33 : 0;
            stall_pct   = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 33 : 0;
            write_reg(slbt_pkg::CFG_ANIM_MODE, {1'b0, PHASE_MODE[p]});
            write_reg(slbt_pkg::CFG_LED_PIN,
                      (p == 0) ? 3'd7 : (p == 1) ? 3'd0 : 3'($urandom_range(7)));
            // hold the result side while ticks keep coming
            if (p == 4)
                hold_cycles = 300;
            if (p == 3)
                press_button(slbt_pkg::FUNC_MAIN, 502, 3, 1'b0);
            else
                random_items(10);
        end

        tick_ch.valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status_led_and_button_tick verification clean");
        else
            $display("status_led_and_button_tick verification failed");
        $finish;
    end

endmodule
